// ----- rtl/ampg_pkg.sv -----
`timescale 1ns / 1ps
package ampg_pkg;

    // fixed field widths
    localparam int IN_POS_W   = 24;
    localparam int TIME_W     = 17;
    localparam int RAD_W      = 20;
    localparam int CFG_ANG_W  = 18;
    localparam int HEAD_W     = 19;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // internal widths
    localparam int ANG_W   = 16;  // wrapped angle, [0, 46080)
    localparam int ASUM_W  = 22;  // angle sums before wrapping
    localparam int DELTA_W = 21;
    localparam int XY_W    = 32;  // cordic x/y, q30
    localparam int Z_W     = 32;  // cordic residual angle, 2^-23 degree
    localparam int MA_W    = 21;  // multiplier operand a
    localparam int PROD_W  = MA_W + XY_W;
    localparam int SC_W    = 23;  // radius * trig, q.8
    localparam int ATAN_IDX_W = 5;

    localparam int FULL_TURN     = 46080;
    localparam int QUARTER_TURN  = 11520;
    localparam int EIGHTH_TURN   = 5760;
    localparam int SHRINK_STEP   = 51;
    localparam int HEADING_LIMIT = 184320;
    localparam logic signed [XY_W-1:0] CORDIC_GAIN = 32'sd652032875;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_INITIAL   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BEGIN_ANGLE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_ANGLE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FACING_DIRECTION = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATE_ENABLE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SHRINK_ENABLE    = 3'd5;

    // facing codes
    localparam logic [1:0] FACE_RIGHT = 2'd0;
    localparam logic [1:0] FACE_UP    = 2'd1;
    localparam logic [1:0] FACE_DOWN  = 2'd2;
    localparam logic [1:0] FACE_LEFT  = 2'd3;

    // item modes
    localparam logic MODE_START  = 1'b0;
    localparam logic MODE_UPDATE = 1'b1;

    function automatic logic [ANG_W-1:0] base_angle(input logic [1:0] facing);
        logic [ANG_W-1:0] r;
        unique case (facing)
            FACE_RIGHT: r = 16'd0;
            FACE_UP:    r = 16'd34560;
            FACE_DOWN:  r = 16'd11520;
            FACE_LEFT:  r = 16'd23040;
            default:    r = 16'd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [Z_W-1:0] atan_at(input logic [ATAN_IDX_W-1:0] idx);
        logic signed [Z_W-1:0] r;
        case (idx)
            5'd0:  r = 32'sd377487360;
            5'd1:  r = 32'sd222843801;
            5'd2:  r = 32'sd117744544;
            5'd3:  r = 32'sd59768969;
            5'd4:  r = 32'sd30000467;
            5'd5:  r = 32'sd15014858;
            5'd6:  r = 32'sd7509261;
            5'd7:  r = 32'sd3754860;
            5'd8:  r = 32'sd1877459;
            5'd9:  r = 32'sd938733;
            5'd10: r = 32'sd469367;
            5'd11: r = 32'sd234683;
            5'd12: r = 32'sd117342;
            5'd13: r = 32'sd58671;
            5'd14: r = 32'sd29335;
            5'd15: r = 32'sd14668;
            5'd16: r = 32'sd7334;
            5'd17: r = 32'sd3667;
            5'd18: r = 32'sd1833;
            5'd19: r = 32'sd917;
            5'd20: r = 32'sd458;
            5'd21: r = 32'sd229;
            5'd22: r = 32'sd115;
            5'd23: r = 32'sd57;
            default: r = '0;
        endcase
        return r;
    endfunction

    // reduce into [0, 46080); inputs stay within seven turns either way
    function automatic logic [ANG_W-1:0] wrap_angle(input logic signed [ASUM_W-1:0] v);
        logic signed [ASUM_W-1:0] r;
        r = v;
        for (int k = -7; k <= 7; k++) begin
            if (v >= ASUM_W'(k * FULL_TURN)) begin
                r = v - ASUM_W'(k * FULL_TURN);
            end
        end
        return r[ANG_W-1:0];
    endfunction

endpackage

// ----- rtl/ampg_in_if.sv -----
`timescale 1ns / 1ps
interface ampg_in_if;
    import ampg_pkg::*;

    logic                       valid;
    logic                       ready;
    logic                       mode;
    logic signed [IN_POS_W-1:0] start_x;
    logic signed [IN_POS_W-1:0] start_y;
    logic        [TIME_W-1:0]   time_fraction;

    modport source (
        output valid, mode, start_x, start_y, time_fraction,
        input  ready
    );

    modport sink (
        input  valid, mode, start_x, start_y, time_fraction,
        output ready
    );
endinterface

// ----- rtl/ampg_out_if.sv -----
`timescale 1ns / 1ps
interface ampg_out_if #(
    parameter int POS_WIDTH = 24
);
    import ampg_pkg::*;

    logic                        valid;
    logic                        ready;
    logic signed [POS_WIDTH-1:0] pos_x;
    logic signed [POS_WIDTH-1:0] pos_y;
    logic signed [HEAD_W-1:0]    heading;
    logic                        heading_valid;
    logic        [RAD_W-1:0]     radius_now;

    modport source (
        output valid, pos_x, pos_y, heading, heading_valid, radius_now,
        input  ready
    );

    modport sink (
        input  valid, pos_x, pos_y, heading, heading_valid, radius_now,
        output ready
    );
endinterface

// ----- rtl/arc_motion_point_generator_unit.sv -----
// channel    dir  handshake       payload
// i_item     in   valid / ready   mode, start_x, start_y, time_fraction
// o_result   out  valid / ready   pos_x, pos_y, heading, heading_valid, radius_now
// i_cfg_*    in   write enable    register index, write data (no read-back)
//
// a start beat runs S_PREP, S_ROT, S_MAP, S_MULC, S_MULS and S_OUT; an update beat
// runs S_DELTA and S_ANGLE before them; both are paced by the single shift-add cordic
// unit that does one rotation per cycle, plus one shared multiplier used for sweep * time
// and radius * cos / radius * sin in turn
// one beat is in flight at a time; the input is ready only while idle
// the result sits in an output register, so the next beat is taken while it waits
// reset is synchronous active low and clears control, config and arc state
`timescale 1ns / 1ps
module arc_motion_point_generator_unit #(
    parameter int CORDIC_STAGES = 16,
    parameter int POS_WIDTH     = 24
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    ampg_in_if.sink                        i_item,
    ampg_out_if.source                     o_result,
    input  logic                           i_cfg_we,
    input  logic [ampg_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ampg_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ampg_pkg::*;

    localparam int ITER_W = $clog2(CORDIC_STAGES);
    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_STAGES - 1);
    // wide enough for centre +/- radius term without wrap
    localparam int SUM_W = ((POS_WIDTH > IN_POS_W) ? POS_WIDTH : IN_POS_W) + 1;
    localparam logic signed [SUM_W-1:0] POS_HI =
        {{(SUM_W - POS_WIDTH + 1){1'b0}}, {(POS_WIDTH - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] POS_LO = ~POS_HI;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_DELTA = 9'b000000010,  // sweep * time on the multiplier
        S_ANGLE = 9'b000000100,  // wrap target angle, heading
        S_PREP  = 9'b000001000,  // quadrant fold, cordic seed
        S_ROT   = 9'b000010000,  // one micro-rotation per cycle
        S_MAP   = 9'b000100000,  // quadrant unfold into cos / sin
        S_MULC  = 9'b001000000,  // radius * cos
        S_MULS  = 9'b010000000,  // radius * sin, finish x
        S_OUT   = 9'b100000000   // finish y, load output register
    } t_state;

    function automatic logic signed [POS_WIDTH-1:0] sat_pos(
        input logic signed [SUM_W-1:0] v
    );
        logic signed [SUM_W-1:0] r;
        r = (v > POS_HI) ? POS_HI : ((v < POS_LO) ? POS_LO : v);
        return r[POS_WIDTH-1:0];
    endfunction

    // control, config and arc state
    t_state                         r_state, n_state;
    logic [ITER_W-1:0]              r_iter;
    logic                           r_ov;
    logic signed [CFG_ANG_W-1:0]    r_begin;
    logic signed [CFG_ANG_W-1:0]    r_sweep;
    logic [1:0]                     r_facing;
    logic                           r_rotate_en;
    logic                           r_shrink_en;
    logic [RAD_W-1:0]               r_radius;
    logic signed [POS_WIDTH-1:0]    r_cx;
    logic signed [POS_WIDTH-1:0]    r_cy;
    logic [ANG_W-1:0]               r_arm;

    // datapath
    logic                           r_mode;
    logic signed [POS_WIDTH-1:0]    r_sx;
    logic signed [POS_WIDTH-1:0]    r_sy;
    logic [TIME_W-1:0]              r_t;
    logic [ANG_W-1:0]               r_ang;
    logic signed [HEAD_W-1:0]       r_head;
    logic signed [XY_W-1:0]         r_x;
    logic signed [XY_W-1:0]         r_y;
    logic signed [Z_W-1:0]          r_z;
    logic [1:0]                     r_quad;
    logic signed [PROD_W-1:0]       r_prod;
    logic signed [POS_WIDTH-1:0]    r_px;

    // output register
    logic signed [POS_WIDTH-1:0]    r_o_x;
    logic signed [POS_WIDTH-1:0]    r_o_y;
    logic signed [HEAD_W-1:0]       r_o_head;
    logic                           r_o_hv;
    logic [RAD_W-1:0]               r_o_rad;

    logic acc;
    logic out_load;

    assign i_item.ready = (r_state == S_IDLE);
    assign acc          = i_item.valid & i_item.ready;
    assign out_load     = (r_state == S_OUT) & (~r_ov | o_result.ready);

    assign o_result.valid         = r_ov;
    assign o_result.pos_x         = r_o_x;
    assign o_result.pos_y         = r_o_y;
    assign o_result.heading       = r_o_head;
    assign o_result.heading_valid = r_o_hv;
    assign o_result.radius_now    = r_o_rad;

    // start position saturated into the position format
    logic signed [POS_WIDTH-1:0] in_sx, in_sy;
    assign in_sx = sat_pos(SUM_W'(i_item.start_x));
    assign in_sy = sat_pos(SUM_W'(i_item.start_y));

    // arm angle from the live registers, a quarter turn back against the sweep
    logic signed [ASUM_W-1:0] arm_sum;
    logic [ANG_W-1:0]         arm_new;
    always_comb begin
        arm_sum = ASUM_W'(r_begin)
                - $signed({{(ASUM_W - ANG_W){1'b0}}, base_angle(r_facing)});
        if (r_sweep > 0) begin
            arm_sum = arm_sum - ASUM_W'(QUARTER_TURN);
        end else begin
            arm_sum = arm_sum + ASUM_W'(QUARTER_TURN);
        end
        arm_new = wrap_angle(arm_sum);
    end

    // shared multiplier: sweep * time, then radius * cos, radius * sin
    logic signed [MA_W-1:0]   mul_a;
    logic signed [XY_W-1:0]   mul_b;
    logic signed [PROD_W-1:0] mul_p;
    always_comb begin
        case (r_state)
            S_DELTA: begin
                mul_a = MA_W'(r_sweep);
                mul_b = $signed({{(XY_W - TIME_W){1'b0}}, r_t});
            end
            S_MULC: begin
                mul_a = $signed({1'b0, r_radius});
                mul_b = r_x;
            end
            default: begin
                mul_a = $signed({1'b0, r_radius});
                mul_b = r_y;
            end
        endcase
        mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // sweep * time rounded to 1/128 degree, halves up
    logic signed [PROD_W-1:0]  delta_rnd;
    logic signed [DELTA_W-1:0] delta;
    logic signed [ASUM_W-1:0]  head_sum;
    logic signed [ASUM_W-1:0]  head_neg;
    logic signed [HEAD_W-1:0]  head_sat;
    always_comb begin
        delta_rnd = r_prod + PROD_W'(32768);
        delta     = delta_rnd[16 +: DELTA_W];
        head_sum  = ASUM_W'(r_begin) + ASUM_W'(delta);
        head_neg  = -head_sum;
        if (head_neg > ASUM_W'(HEADING_LIMIT)) begin
            head_sat = HEAD_W'(HEADING_LIMIT);
        end else if (head_neg < -ASUM_W'(HEADING_LIMIT)) begin
            head_sat = -HEAD_W'(HEADING_LIMIT);
        end else begin
            head_sat = head_neg[HEAD_W-1:0];
        end
    end

    // quadrant fold of the target angle, nearest multiple of a quarter turn
    logic [2:0]              qcnt;
    logic signed [17:0]      zdiff;
    logic signed [Z_W-1:0]   z_seed;
    always_comb begin
        if (r_ang >= ANG_W'(EIGHTH_TURN + 3 * QUARTER_TURN)) begin
            qcnt  = 3'd4;
            zdiff = $signed({2'b00, r_ang}) - 18'sd46080;
        end else if (r_ang >= ANG_W'(EIGHTH_TURN + 2 * QUARTER_TURN)) begin
            qcnt  = 3'd3;
            zdiff = $signed({2'b00, r_ang}) - 18'sd34560;
        end else if (r_ang >= ANG_W'(EIGHTH_TURN + QUARTER_TURN)) begin
            qcnt  = 3'd2;
            zdiff = $signed({2'b00, r_ang}) - 18'sd23040;
        end else if (r_ang >= ANG_W'(EIGHTH_TURN)) begin
            qcnt  = 3'd1;
            zdiff = $signed({2'b00, r_ang}) - 18'sd11520;
        end else begin
            qcnt  = 3'd0;
            zdiff = $signed({2'b00, r_ang});
        end
        // 1/128 degree to 2^-23 degree
        z_seed = Z_W'(zdiff) <<< 16;
    end

    // one cordic micro-rotation
    logic signed [XY_W-1:0] x_sh, y_sh, x_rot, y_rot;
    logic signed [Z_W-1:0]  z_rot, atan_i;
    always_comb begin
        x_sh   = r_x >>> r_iter;
        y_sh   = r_y >>> r_iter;
        atan_i = atan_at(ATAN_IDX_W'(r_iter));
        if (r_z >= 0) begin
            x_rot = r_x - y_sh;
            y_rot = r_y + x_sh;
            z_rot = r_z - atan_i;
        end else begin
            x_rot = r_x + y_sh;
            y_rot = r_y - x_sh;
            z_rot = r_z + atan_i;
        end
    end

    // quadrant unfold
    logic signed [XY_W-1:0] cos_v, sin_v;
    always_comb begin
        case (r_quad)
            QUAD_0:  begin cos_v = r_x;  sin_v = r_y;  end
            QUAD_1:  begin cos_v = -r_y; sin_v = r_x;  end
            QUAD_2:  begin cos_v = -r_x; sin_v = -r_y; end
            QUAD_3:  begin cos_v = r_y;  sin_v = -r_x; end
            default: begin cos_v = r_x;  sin_v = r_y;  end
        endcase
    end

    // radius * trig rounded to q.8, then centre + term, or start - term for a start beat; x in S_MULS, y in S_OUT
    logic signed [PROD_W-1:0]    sc_rnd;
    logic signed [SC_W-1:0]      sc;
    logic signed [SUM_W-1:0]     pick_c, pick_s, pt_sum;
    logic signed [POS_WIDTH-1:0] pt_sat;
    always_comb begin
        sc_rnd = r_prod + PROD_W'(64'sd1 <<< 29);
        sc     = sc_rnd[30 +: SC_W];
        pick_c = (r_state == S_MULS) ? SUM_W'(r_cx) : SUM_W'(r_cy);
        pick_s = (r_state == S_MULS) ? SUM_W'(r_sx) : SUM_W'(r_sy);
        if (r_mode == MODE_UPDATE) begin
            pt_sum = pick_c + SUM_W'(sc);
        end else begin
            pt_sum = pick_s - SUM_W'(sc);
        end
        pt_sat = sat_pos(pt_sum);
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_state = (i_item.mode == MODE_UPDATE) ? S_DELTA : S_PREP;
                end
            end
            S_DELTA: n_state = S_ANGLE;
            S_ANGLE: n_state = S_PREP;
            S_PREP:  n_state = S_ROT;
            S_ROT: begin
                if (r_iter == ITER_LAST) begin
                    n_state = S_MAP;
                end
            end
            S_MAP:  n_state = S_MULC;
            S_MULC: n_state = S_MULS;
            S_MULS: n_state = S_OUT;
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_iter      <= '0;
            r_ov        <= 1'b0;
            r_begin     <= '0;
            r_sweep     <= '0;
            r_facing    <= FACE_RIGHT;
            r_rotate_en <= 1'b1;
            r_shrink_en <= 1'b0;
            r_radius    <= '0;
            r_cx        <= '0;
            r_cy        <= '0;
            r_arm       <= '0;
        end else begin
            r_state <= n_state;

            if (r_state == S_PREP) begin
                r_iter <= '0;
            end else if (r_state == S_ROT) begin
                r_iter <= r_iter + 1'b1;
            end

            if (out_load) begin
                r_ov <= 1'b1;
            end else if (o_result.ready) begin
                r_ov <= 1'b0;
            end

            if (acc) begin
                if (i_item.mode == MODE_START) begin
                    r_arm <= arm_new;
                end else if (r_shrink_en) begin
                    // shrink by 51/256 pixel, floor at zero
                    r_radius <= (r_radius > RAD_W'(SHRINK_STEP))
                              ? r_radius - RAD_W'(SHRINK_STEP) : '0;
                end
            end

            if (r_state == S_MULS && r_mode == MODE_START) begin
                r_cx <= pt_sat;
            end
            if (out_load && r_mode == MODE_START) begin
                r_cy <= pt_sat;
            end

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_RADIUS_INITIAL:   r_radius    <= i_cfg_data[RAD_W-1:0];
                    CFG_BEGIN_ANGLE:      r_begin     <= $signed(i_cfg_data[CFG_ANG_W-1:0]);
                    CFG_SWEEP_ANGLE:      r_sweep     <= $signed(i_cfg_data[CFG_ANG_W-1:0]);
                    CFG_FACING_DIRECTION: r_facing    <= i_cfg_data[1:0];
                    CFG_ROTATE_ENABLE:    r_rotate_en <= i_cfg_data[0];
                    CFG_SHRINK_ENABLE:    r_shrink_en <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_mode <= i_item.mode;
            r_sx   <= in_sx;
            r_sy   <= in_sy;
            r_t    <= i_item.time_fraction;
            r_head <= '0;
            if (i_item.mode == MODE_START) begin
                r_ang <= arm_new;
            end
        end

        if (r_state == S_DELTA || r_state == S_MULC || r_state == S_MULS) begin
            r_prod <= mul_p;
        end

        if (r_state == S_ANGLE) begin
            r_ang  <= wrap_angle(ASUM_W'($signed({1'b0, r_arm})) + ASUM_W'(delta));
            r_head <= head_sat;
        end

        if (r_state == S_PREP) begin
            r_x    <= CORDIC_GAIN;
            r_y    <= '0;
            r_z    <= z_seed;
            r_quad <= qcnt[1:0];
        end else if (r_state == S_ROT) begin
            r_x <= x_rot;
            r_y <= y_rot;
            r_z <= z_rot;
        end else if (r_state == S_MAP) begin
            r_x <= cos_v;
            r_y <= sin_v;
        end

        if (r_state == S_MULS) begin
            r_px <= (r_mode == MODE_UPDATE) ? pt_sat : r_sx;
        end

        if (out_load) begin
            r_o_x    <= r_px;
            r_o_y    <= (r_mode == MODE_UPDATE) ? pt_sat : r_sy;
            r_o_head <= r_head;
            r_o_hv   <= (r_mode == MODE_UPDATE) & r_rotate_en;
            r_o_rad  <= r_radius;
        end
    end

`ifndef SYNTH
    // a result never appears in the cycle right after a beat is taken
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> !$rose(r_ov))
        else $error("result raised right after input beat");

    // rotation counter stays inside the stage count
    a_iter_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROT) |-> (r_iter <= ITER_LAST))
        else $error("cordic iteration out of range");

    // radius only shrinks unless reloaded by a register write
    a_radius_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cfg_we && i_cfg_idx == CFG_RADIUS_INITIAL) |=> (r_radius <= $past(r_radius)))
        else $error("radius grew without a reload");

    // a start result never carries a heading
    a_start_no_heading: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && r_mode == MODE_START) |=> (r_o_head == '0 && !r_o_hv))
        else $error("start result carries a heading");
`endif

endmodule
